>>> hw/rtl/qalu_pkg.sv
// Shared types and operation codes for the Q16.16 fixed-point ALU.
`default_nettype none
package qalu_pkg;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_MUL      = 4'd2,
    FN_DIV      = 4'd3,
    FN_NEG      = 4'd4,
    FN_AND      = 4'd5,
    FN_OR       = 4'd6,
    FN_XOR      = 4'd7,
    FN_NOT      = 4'd8,
    FN_SHL      = 4'd9,
    FN_SHR      = 4'd10,
    FN_FROM_INT = 4'd11,
    FN_TO_INT   = 4'd12,
    FN_RSV13    = 4'd13,
    FN_RSV14    = 4'd14,
    FN_RSV15    = 4'd15
  } func_t;

  localparam int unsigned WORD_W = 32;

  // Per-stage payload that rides along the divider pipeline.
  typedef struct packed {
    func_t             fn;
    logic [WORD_W-1:0] res;
    logic              ovf;
    logic              lt;
    logic              eq;
    logic              gt;
    logic              dz;
    logic              neg;
  } pay_t;

endpackage
`default_nettype wire

>>> hw/rtl/q16_16_fixed_point_alu_core.sv
// Top level of the pipelined signed fixed-point ALU.
`default_nettype none
// Signed fixed-point ALU (FRAC_BITS fraction bits) with valid/ready channels.
// One transaction is accepted every cycle while the output is not stalled;
// the pipeline depth is set by the restoring divider, which resolves one
// quotient bit per pipeline stage. All operations pass through the same
// stages, so results leave in order. An output stall holds the whole pipeline.
module q16_16_fixed_point_alu_core
  import qalu_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  func,
  input  wire logic [31:0] operand_a,
  input  wire logic [31:0] operand_b,
  input  wire logic [4:0]  shift_amount,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result,
  output logic             less,
  output logic             equal,
  output logic             greater,
  output logic             overflow,
  output logic             div_by_zero
);

  localparam int unsigned DW = WORD_W + FRAC_BITS;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // input register
  logic        s0_vld;
  func_t       s0_fn;
  logic [31:0] s0_a, s0_b;
  logic [4:0]  s0_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_fn <= func_t'(func);
      s0_a  <= operand_a;
      s0_b  <= operand_b;
      s0_sh <= shift_amount;
    end
  end

  // pipeline arrays, index 0 is the decode stage
  logic              vld [0:DW];
  pay_t              pay [0:DW];
  logic [31:0]       rem [0:DW];
  logic [DW-1:0]     dq  [0:DW];
  logic [31:0]       dvs [0:DW];
  logic signed [63:0] prod;

  // decode / simple ops
  pay_t        p1_next;
  logic [32:0] sum;
  logic [63:0] wide;
  logic [31:0] mag_a, mag_b;

  always_comb begin
    p1_next     = '0;
    p1_next.fn  = s0_fn;
    p1_next.lt  = $signed(s0_a) < $signed(s0_b);
    p1_next.eq  = s0_a == s0_b;
    p1_next.gt  = $signed(s0_a) > $signed(s0_b);
    p1_next.neg = s0_a[31] ^ s0_b[31];
    sum  = '0;
    wide = '0;
    case (s0_fn)
      FN_ADD: begin
        sum = {s0_a[31], s0_a} + {s0_b[31], s0_b};
        p1_next.res = sum[31:0];
        p1_next.ovf = sum[32] ^ sum[31];
      end
      FN_SUB: begin
        sum = {s0_a[31], s0_a} - {s0_b[31], s0_b};
        p1_next.res = sum[31:0];
        p1_next.ovf = sum[32] ^ sum[31];
      end
      FN_NEG: begin
        sum = 33'd0 - {s0_a[31], s0_a};
        p1_next.res = sum[31:0];
        p1_next.ovf = sum[32] ^ sum[31];
      end
      FN_DIV:  p1_next.dz = s0_b == 32'd0;
      FN_AND:  p1_next.res = s0_a & s0_b;
      FN_OR:   p1_next.res = s0_a | s0_b;
      FN_XOR:  p1_next.res = s0_a ^ s0_b;
      FN_NOT:  p1_next.res = ~s0_a;
      FN_SHL: begin
        wide = {{32{s0_a[31]}}, s0_a} << s0_sh;
        p1_next.res = wide[31:0];
        p1_next.ovf = wide[63:31] != {33{wide[31]}};
      end
      FN_FROM_INT: begin
        wide = {{32{s0_a[31]}}, s0_a} << FRAC_BITS;
        p1_next.res = wide[31:0];
        p1_next.ovf = wide[63:31] != {33{wide[31]}};
      end
      FN_SHR:    p1_next.res = $signed(s0_a) >>> s0_sh;
      FN_TO_INT: p1_next.res = $signed(s0_a) >>> FRAC_BITS;
      default: ;
    endcase
    mag_a = s0_a[31] ? (32'd0 - s0_a) : s0_a;
    mag_b = s0_b[31] ? (32'd0 - s0_b) : s0_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s0_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pay[0] <= p1_next;
      prod   <= $signed(s0_a) * $signed(s0_b);
      rem[0] <= '0;
      dq[0]  <= {mag_a, {FRAC_BITS{1'b0}}};
      dvs[0] <= mag_b;
    end
  end

  // one quotient bit per stage; first stage also finishes the multiply
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [32:0] t, d;
    logic        ge;
    logic [63:0] psh;
    pay_t        pn;

    always_comb begin
      t   = {rem[k], dq[k][DW-1]};
      ge  = t >= {1'b0, dvs[k]};
      d   = t - {1'b0, dvs[k]};
      psh = prod >>> FRAC_BITS;
      pn  = pay[k];
      if (k == 0 && pay[k].fn == FN_MUL) begin
        pn.res = psh[31:0];
        pn.ovf = psh[63:31] != {33{psh[31]}};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (adv) begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay[k+1] <= pn;
        rem[k+1] <= ge ? d[31:0] : t[31:0];
        dq[k+1]  <= {dq[k][DW-2:0], ge};
        dvs[k+1] <= dvs[k];
      end
    end
  end

  // sign fixup and output register
  localparam logic [DW-1:0] LIM = DW'(1) << 31;
  logic [DW-1:0] qn;
  pay_t          fin;

  always_comb begin
    fin = pay[DW];
    qn  = pay[DW].neg ? (DW'(0) - dq[DW]) : dq[DW];
    if (pay[DW].fn == FN_DIV) begin
      if (pay[DW].dz) begin
        fin.res = '0;
        fin.ovf = 1'b0;
      end else begin
        fin.res = qn[31:0];
        fin.ovf = pay[DW].neg ? (dq[DW] > LIM) : (dq[DW] >= LIM);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result      <= fin.res;
      less        <= fin.lt;
      equal       <= fin.eq;
      greater     <= fin.gt;
      overflow    <= fin.ovf;
      div_by_zero <= fin.dz;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/qalu_checker.sv
// Port-level checker for the fixed-point ALU and its bind.
`default_nettype none
module qalu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] result,
  input wire logic        less,
  input wire logic        equal,
  input wire logic        greater,
  input wire logic        overflow,
  input wire logic        div_by_zero
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result))
    else $error("output transaction changed while stalled");

  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && div_by_zero |-> result == 32'd0 && !overflow)
    else $error("divide by zero result not cleared");

  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $countones({less, equal, greater}) == 1)
    else $error("compare flags not exclusive");

  a_rst: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind q16_16_fixed_point_alu_core qalu_checker u_qalu_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .result(result), .less(less), .equal(equal), .greater(greater),
  .overflow(overflow), .div_by_zero(div_by_zero)
);
`default_nettype wire
